@@ rtl/conv3x3_relu_requant_top_macros.svh @@
// Assertion macros shared by the convolution block.
`ifndef CONV3X3_RELU_REQUANT_TOP_MACROS_SVH
`define CONV3X3_RELU_REQUANT_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define C3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define C3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/c3rq_pkg.sv @@
// Shared types and codes of the 3x3 convolution block.
package c3rq_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_ACT    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEIGHT    = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_IN_CH     = 3'd2;
    localparam logic [2:0] REG_OUT_CH    = 3'd3;
    localparam logic [2:0] REG_LSHIFT    = 3'd4;
    localparam logic [2:0] REG_RSHIFT    = 3'd5;

    // Requantization ceiling.
    localparam logic [15:0] CLIP_MAX = 16'd15;

    // Shift settings that the datapath needs.
    typedef struct packed {
        logic [2:0] left_shift;
        logic [2:0] right_shift;
    } t_shift_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic act_we;
        logic wgt_we;
        logic bias_we;
        logic clear;
        logic issue;
        logic fin;
        logic emit;
        logic last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/c3rq_datapath.sv @@
// Datapath: weight, bias and row stores, MAC accumulator, requantizer, output register.
module c3rq_datapath
    import c3rq_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    localparam int RDEPTH = 3 * MAX_WIDTH * MAX_IN_CH,
    localparam int RA     = $clog2(RDEPTH),
    localparam int WDEPTH = 9 * MAX_IN_CH * MAX_OUT_CH,
    localparam int WA     = $clog2(WDEPTH),
    localparam int BA     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  t_shift_cfg    i_cfg,
    input  logic [RA-1:0] i_row_waddr,
    input  logic [RA-1:0] i_row_raddr,
    input  logic [3:0]    i_act,
    input  logic [WA-1:0] i_wgt_waddr,
    input  logic [WA-1:0] i_wgt_raddr,
    input  logic [3:0]    i_wgt,
    input  logic [BA-1:0] i_bias_waddr,
    input  logic [BA-1:0] i_bias_raddr,
    input  logic [7:0]    i_bias,
    input  logic [3:0]    i_chan,
    input  logic [4:0]    i_row,
    input  logic [4:0]    i_col,
    input  logic          i_out_ready,
    output t_dp_status    o_status,
    output logic          o_out_valid,
    output logic [3:0]    o_value,
    output logic [3:0]    o_chan,
    output logic [4:0]    o_row,
    output logic [4:0]    o_col,
    output logic          o_last
);

    logic [3:0]  r_row_mem [RDEPTH];
    logic [3:0]  r_wgt_mem [WDEPTH];
    logic [7:0]  r_bias [MAX_OUT_CH];
    logic [3:0]  r_x;
    logic [3:0]  r_w;
    logic        r_mac_vld;
    logic [15:0] r_acc;
    logic [15:0] r_post;
    logic        r_out_valid;
    logic [3:0]  r_value;
    logic [3:0]  r_chan;
    logic [4:0]  r_row;
    logic [4:0]  r_col;
    logic        r_last;

    logic signed [8:0] w_prod;
    logic [15:0] w_shifted;
    logic [15:0] w_sum;
    logic [15:0] w_mask;
    logic [15:0] w_mid;
    logic [15:0] w_frac;
    logic [15:0] w_q;
    logic [15:0] w_qr;
    logic [3:0]  n_value;

    // Row and weight stores with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.act_we) begin
            r_row_mem[i_row_waddr] <= i_act;
        end
        if (i_cmd.wgt_we) begin
            r_wgt_mem[i_wgt_waddr] <= i_wgt;
        end
        if (i_cmd.issue) begin
            r_x <= r_row_mem[i_row_raddr];
            r_w <= r_wgt_mem[i_wgt_raddr];
        end
        if (i_cmd.bias_we) begin
            r_bias[i_bias_waddr] <= i_bias;
        end
    end

    // Signed weight times unsigned activation.
    assign w_prod = $signed(r_w) * $signed({1'b0, r_x});

    // Post-processing: left shift, bias add and ReLU.
    assign w_shifted = r_acc << i_cfg.left_shift;
    assign w_sum     = w_shifted + {{8{r_bias[i_bias_raddr][7]}}, r_bias[i_bias_raddr]};

    // Right shift by right_shift+1 with round half to even, then clip.
    always_comb begin
        w_mid  = 16'd1 << i_cfg.right_shift;
        w_mask = (w_mid << 1) - 16'd1;
        w_frac = r_post & w_mask;
        w_q    = r_post >> (i_cfg.right_shift + 3'd1);
        w_qr   = w_q;
        if (w_frac > w_mid || (w_frac == w_mid && w_q[0])) begin
            w_qr = w_q + 16'd1;
        end
        n_value = (w_qr > CLIP_MAX) ? 4'd15 : w_qr[3:0];
    end

    // Accumulator and post-processing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_vld <= 1'b0;
            r_acc     <= 16'd0;
        end else begin
            r_mac_vld <= i_cmd.issue;
            if (i_cmd.clear) begin
                r_acc <= 16'd0;
            end else if (r_mac_vld) begin
                r_acc <= r_acc + {{7{w_prod[8]}}, w_prod};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_post <= w_sum[15] ? 16'd0 : w_sum;
        end
    end

    // Output register: one result item waits here for the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_value <= n_value;
            r_chan  <= i_chan;
            r_row   <= i_row;
            r_col   <= i_col;
            r_last  <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_chan      = r_chan;
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_last      = r_last;

endmodule

@@ rtl/c3rq_ctrl.sv @@
// Controller: configuration, frame counters and the MAC sequencer.
module c3rq_ctrl
    import c3rq_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    localparam int RDEPTH = 3 * MAX_WIDTH * MAX_IN_CH,
    localparam int RA     = $clog2(RDEPTH),
    localparam int WDEPTH = 9 * MAX_IN_CH * MAX_OUT_CH,
    localparam int WA     = $clog2(WDEPTH),
    localparam int BA     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1,
    localparam int COLW   = $clog2(MAX_WIDTH),
    localparam int CW     = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [5:0]    i_cfg_data,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    input  logic [11:0]   i_wgt_index,
    input  logic [3:0]    i_bias_index,
    input  t_dp_status    i_status,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd,
    output t_shift_cfg    o_cfg,
    output logic [RA-1:0] o_row_waddr,
    output logic [RA-1:0] o_row_raddr,
    output logic [WA-1:0] o_wgt_waddr,
    output logic [WA-1:0] o_wgt_raddr,
    output logic [BA-1:0] o_bias_waddr,
    output logic [BA-1:0] o_bias_raddr,
    output logic [3:0]    o_chan,
    output logic [4:0]    o_row,
    output logic [4:0]    o_col
);

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_TAIL, S_FIN, S_EMIT} t_state;

    localparam int WMAX = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam int IMAX = (MAX_IN_CH < 16) ? MAX_IN_CH : 16;
    localparam int OMAX = (MAX_OUT_CH < 16) ? MAX_OUT_CH : 16;

    t_state          r_state;
    logic [5:0]      r_height;
    logic [5:0]      r_width;
    logic [4:0]      r_in_ch;
    logic [4:0]      r_out_ch;
    logic [2:0]      r_lshift;
    logic [2:0]      r_rshift;
    logic [4:0]      r_row;
    logic [COLW-1:0] r_col;
    logic [CW-1:0]   r_ch;
    logic [1:0]      r_slot;
    logic [4:0]      r_wrow;
    logic [COLW-1:0] r_wcol;
    logic [1:0]      r_wslot;
    logic [1:0]      r_kr;
    logic [1:0]      r_kc;
    logic [CW-1:0]   r_fi;
    logic [4:0]      r_fo;
    logic [WA-1:0]   r_wi;

    logic       w_accept;
    logic       w_pix_done;
    logic       w_window;
    logic       w_mac_last;
    logic       w_fo_last;
    logic [2:0] w_rsum;
    logic [1:0] w_rslot;

    // Saturate a register value into its range.
    function automatic logic [5:0] clamp6(input logic [5:0] v, input logic [5:0] lo,
                                          input logic [5:0] hi);
        logic [5:0] res;
        res = v;
        if (v < lo) res = lo;
        if (v > hi) res = hi;
        return res;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pix_done = (6'(r_ch) + 6'd1 >= 6'(r_in_ch));
    assign w_window   = (r_row >= 5'd2) && (7'(r_col) >= 7'd2);
    assign w_mac_last = (r_kr == 2'd2) && (r_kc == 2'd2) && (6'(r_fi) + 6'd1 == 6'(r_in_ch));
    assign w_fo_last  = (r_fo + 5'd1 == r_out_ch);

    // Window row slot: oldest row first, the current row last.
    assign w_rsum  = 3'(r_wslot) + 3'(r_kr) + 3'd1;
    assign w_rslot = (w_rsum >= 3'd3) ? 2'(w_rsum - 3'd3) : w_rsum[1:0];

    // Store addresses.
    assign o_row_waddr = (RA'(r_slot) * RA'(MAX_WIDTH) + RA'(r_col)) * RA'(MAX_IN_CH)
                         + RA'(r_ch);
    assign o_row_raddr = (RA'(w_rslot) * RA'(MAX_WIDTH) + RA'(r_wcol) + RA'(r_kc))
                         * RA'(MAX_IN_CH) + RA'(r_fi);
    assign o_wgt_waddr  = WA'(i_wgt_index);
    assign o_wgt_raddr  = r_wi;
    assign o_bias_waddr = BA'(i_bias_index);
    assign o_bias_raddr = BA'(r_fo);
    assign o_chan       = r_fo[3:0];
    assign o_row        = r_wrow;
    assign o_col        = 5'(r_wcol);
    assign o_cfg.left_shift  = r_lshift;
    assign o_cfg.right_shift = r_rshift;

    // Datapath commands decoded from state and the accepted item.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.wgt_we  = (i_op == OP_WEIGHT) && (32'(i_wgt_index) < WDEPTH);
                    o_cmd.bias_we = (i_op == OP_BIAS) && (32'(i_bias_index) < MAX_OUT_CH);
                    o_cmd.act_we  = (i_op == OP_ACT);
                    o_cmd.clear   = (i_op == OP_ACT);
                end
            end
            S_MAC:  o_cmd.issue = 1'b1;
            S_TAIL: ;
            S_FIN:  o_cmd.fin = 1'b1;
            S_EMIT: begin
                o_cmd.emit  = i_status.out_free;
                o_cmd.last  = w_fo_last;
                o_cmd.clear = i_status.out_free;
            end
            default: ;
        endcase
    end

    // State, configuration and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_height <= 6'd32;
            r_width  <= 6'(WMAX);
            r_in_ch  <= 5'd1;
            r_out_ch <= 5'd1;
            r_lshift <= 3'd0;
            r_rshift <= 3'd0;
            r_row    <= '0;
            r_col    <= '0;
            r_ch     <= '0;
            r_slot   <= '0;
            r_wrow   <= '0;
            r_wcol   <= '0;
            r_wslot  <= '0;
            r_kr     <= '0;
            r_kc     <= '0;
            r_fi     <= '0;
            r_fo     <= '0;
            r_wi     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_op == OP_ACT) begin
                        if (w_pix_done) begin
                            r_ch <= '0;
                            if (w_window) begin
                                r_wrow  <= r_row - 5'd2;
                                r_wcol  <= r_col - COLW'(2);
                                r_wslot <= r_slot;
                                r_kr    <= '0;
                                r_kc    <= '0;
                                r_fi    <= '0;
                                r_fo    <= '0;
                                r_wi    <= '0;
                                r_state <= S_MAC;
                            end
                            if (7'(r_col) + 7'd1 >= 7'(r_width)) begin
                                r_col <= '0;
                                if (6'(r_row) + 6'd1 >= r_height) begin
                                    r_row  <= '0;
                                    r_slot <= '0;
                                end else begin
                                    r_row  <= r_row + 5'd1;
                                    r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                                end
                            end else begin
                                r_col <= r_col + COLW'(1);
                            end
                        end else begin
                            r_ch <= r_ch + CW'(1);
                        end
                    end
                end
                S_MAC: begin
                    r_wi <= r_wi + WA'(1);
                    if (6'(r_fi) + 6'd1 == 6'(r_in_ch)) begin
                        r_fi <= '0;
                        if (r_kc == 2'd2) begin
                            r_kc <= '0;
                            r_kr <= r_kr + 2'd1;
                        end else begin
                            r_kc <= r_kc + 2'd1;
                        end
                    end else begin
                        r_fi <= r_fi + CW'(1);
                    end
                    if (w_mac_last) begin
                        r_kr    <= '0;
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: r_state <= S_FIN;
                S_FIN:  r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (w_fo_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_fo    <= r_fo + 5'd1;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // A write to one of the configuration registers restarts the frame; a write to an unused index does not.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HEIGHT: r_height <= clamp6(i_cfg_data, 6'd3, 6'd32);
                    REG_WIDTH:  r_width  <= clamp6(i_cfg_data, 6'd3, 6'(WMAX));
                    REG_IN_CH:  r_in_ch  <= 5'(clamp6({1'b0, i_cfg_data[4:0]}, 6'd1,
                                                      6'(IMAX)));
                    REG_OUT_CH: r_out_ch <= 5'(clamp6({1'b0, i_cfg_data[4:0]}, 6'd1,
                                                      6'(OMAX)));
                    REG_LSHIFT: r_lshift <= i_cfg_data[2:0];
                    REG_RSHIFT: r_rshift <= (i_cfg_data[2:0] > 3'd6) ? 3'd6
                                                                      : i_cfg_data[2:0];
                    default: ;
                endcase
                if (i_cfg_idx <= REG_RSHIFT) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_ch   <= '0;
                    r_slot <= '0;
                end
            end
        end
    end

endmodule

@@ rtl/conv3x3_relu_requant_top.sv @@
// Top level of the streaming 3x3 convolution with ReLU and requantization.
//
// Channel  Dir  Handshake              Payload
// s        in   i_s_tvalid/o_s_tready  i_s_tdata (32), i_s_tuser (2, op)
// m        out  o_m_tvalid/i_m_tready  o_m_tdata (24), o_m_tlast
// cfg      in   i_cfg_we               i_cfg_idx (3), i_cfg_data (6)
//
// Weight, bias and non-window activation items are written without leaving idle.
// An activation item that completes a window then runs, per output channel,
// MAC steps at one MAC per cycle through the shared multiplier with
// single-port store reads, plus read latency, bias/ReLU and requantize
// steps. Reset is synchronous and active low; the stores are not
// cleared. A stalled output holds its item and the sequencer waits for it.
module conv3x3_relu_requant_top
    import c3rq_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // weight_index[11:0], weight_value[15:12], bias_index[19:16],
    // bias_value[27:20], activation[31:28]
    input  logic [31:0] i_s_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_value[3:0], out_channel[7:4], out_row[12:8], out_col[17:13], zero above
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int RA = $clog2(3 * MAX_WIDTH * MAX_IN_CH);
    localparam int WA = $clog2(9 * MAX_IN_CH * MAX_OUT_CH);
    localparam int BA = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;

    t_dp_cmd       w_cmd;
    t_dp_status    w_status;
    t_shift_cfg    w_cfg;
    logic [RA-1:0] w_row_waddr;
    logic [RA-1:0] w_row_raddr;
    logic [WA-1:0] w_wgt_waddr;
    logic [WA-1:0] w_wgt_raddr;
    logic [BA-1:0] w_bias_waddr;
    logic [BA-1:0] w_bias_raddr;
    logic [3:0]    w_chan;
    logic [4:0]    w_row;
    logic [4:0]    w_col;
    logic [3:0]    w_o_value;
    logic [3:0]    w_o_chan;
    logic [4:0]    w_o_row;
    logic [4:0]    w_o_col;

    c3rq_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_IN_CH (MAX_IN_CH),
        .MAX_OUT_CH(MAX_OUT_CH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_tvalid),
        .i_op        (i_s_tuser),
        .i_wgt_index (i_s_tdata[11:0]),
        .i_bias_index(i_s_tdata[19:16]),
        .i_status    (w_status),
        .o_in_ready  (o_s_tready),
        .o_cmd       (w_cmd),
        .o_cfg       (w_cfg),
        .o_row_waddr (w_row_waddr),
        .o_row_raddr (w_row_raddr),
        .o_wgt_waddr (w_wgt_waddr),
        .o_wgt_raddr (w_wgt_raddr),
        .o_bias_waddr(w_bias_waddr),
        .o_bias_raddr(w_bias_raddr),
        .o_chan      (w_chan),
        .o_row       (w_row),
        .o_col       (w_col)
    );

    c3rq_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_IN_CH (MAX_IN_CH),
        .MAX_OUT_CH(MAX_OUT_CH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_row_waddr (w_row_waddr),
        .i_row_raddr (w_row_raddr),
        .i_act       (i_s_tdata[31:28]),
        .i_wgt_waddr (w_wgt_waddr),
        .i_wgt_raddr (w_wgt_raddr),
        .i_wgt       (i_s_tdata[15:12]),
        .i_bias_waddr(w_bias_waddr),
        .i_bias_raddr(w_bias_raddr),
        .i_bias      (i_s_tdata[27:20]),
        .i_chan      (w_chan),
        .i_row       (w_row),
        .i_col       (w_col),
        .i_out_ready (i_m_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_tvalid),
        .o_value     (w_o_value),
        .o_chan      (w_o_chan),
        .o_row       (w_o_row),
        .o_col       (w_o_col),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_o_col, w_o_row, w_o_chan, w_o_value};

`include "conv3x3_relu_requant_top_macros.svh"

    // A result is loaded only into a free output register.
    `C3_ASSERT_NOW(a_emit_free, w_cmd.emit, !o_m_tvalid || i_m_tready)
    // Store reads for MACs never overlap input acceptance.
    `C3_ASSERT_NOW(a_issue_busy, w_cmd.issue, !o_s_tready)
    // After a weight or bias item, the input is ready again in the next cycle.
    `C3_ASSERT_NEXT(a_write_quick,
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_WEIGHT || i_s_tuser == OP_BIAS),
        o_s_tready)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the streaming 3x3 convolution with ReLU and requantization.
`timescale 1ns / 1ps

module testbench;
    import c3rq_pkg::*;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [2:0] REG_NONE = 3'd6;
    localparam logic [1:0] OP_NONE  = 2'd3;
    localparam int LINE_W    = 32;
    localparam int LINE_CH   = 16;
    localparam int WGT_DEPTH = 2304;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [3:0] value;
        logic [3:0] channel;
        logic [4:0] row;
        logic [4:0] col;
        logic       last;
    } t_pixel_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [5:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;

    conv3x3_relu_requant_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Shadow state of the convolution.
    logic [3:0] weight_mem [WGT_DEPTH];
    logic [7:0] bias_mem [16];
    logic [3:0] line_mem [3 * LINE_W * LINE_CH];
    int unsigned cur_row, cur_col, cur_ch;
    int unsigned frame_h, frame_w, in_ch, out_ch, lshift, rshift;

    t_pixel_out pending_outputs[$];
    int errors;
    int unsigned cycle_count = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Global watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 0;
        if (r < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned line_addr(int unsigned r, int unsigned c, int unsigned ch);
        return ((r % 3) * LINE_W + c) * LINE_CH + ch;
    endfunction

    // Shift right by s+1 with round half to even, then clip to 15.
    function automatic logic [3:0] requantize(logic [15:0] v, int unsigned s);
        int unsigned half, frac, q;
        half = 1 << s;
        frac = v & ((half << 1) - 1);
        q = v >> (s + 1);
        if (frac >= half) q = q + 1;
        if (frac == half && q[0]) q = q - 1;
        return (q > 15) ? 4'd15 : q[3:0];
    endfunction

    // Register write as seen by the block: saturate, then restart the frame.
    function automatic void apply_reg(logic [2:0] idx, logic [5:0] val);
        case (idx)
            REG_HEIGHT: frame_h = clip(val, 3, 32);
            REG_WIDTH:  frame_w = clip(val, 3, 32);
            REG_IN_CH:  in_ch   = clip(val[4:0], 1, 16);
            REG_OUT_CH: out_ch  = clip(val[4:0], 1, 16);
            REG_LSHIFT: lshift  = val[2:0];
            REG_RSHIFT: rshift  = clip(val[2:0], 0, 6);
            default:    return;
        endcase
        cur_row = 0;
        cur_col = 0;
        cur_ch = 0;
    endfunction

    // Work out the results of one accepted item and queue them.
    function automatic void predict_item(logic [1:0] op, logic [31:0] data);
        logic [15:0] acc;
        logic [15:0] prod;
        int w, x;
        int unsigned wi;
        t_pixel_out px;
        if (op == OP_WEIGHT) begin
            if (data[11:0] < WGT_DEPTH) weight_mem[data[11:0]] = data[15:12];
            return;
        end
        if (op == OP_BIAS) begin
            bias_mem[data[19:16]] = data[27:20];
            return;
        end
        if (op != OP_ACT) return;
        line_mem[line_addr(cur_row, cur_col, cur_ch)] = data[31:28];
        if (cur_ch + 1 < in_ch) begin
            cur_ch++;
            return;
        end
        if (cur_row >= 2 && cur_col >= 2) begin
            for (int fo = 0; fo < out_ch; fo++) begin
                acc = '0;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        for (int fi = 0; fi < in_ch; fi++) begin
                            wi = ((fo * 3 + r) * 3 + c) * in_ch + fi;
                            w = $signed(weight_mem[wi]);
                            x = line_mem[line_addr(cur_row - 2 + r, cur_col - 2 + c, fi)];
                            prod = 16'(w * x);
                            acc = acc + prod;
                        end
                acc = acc << lshift;
                acc = acc + {{8{bias_mem[fo][7]}}, bias_mem[fo]};
                if (acc[15]) acc = '0;
                px.value = requantize(acc, rshift);
                px.channel = 4'(fo);
                px.row = 5'(cur_row - 2);
                px.col = 5'(cur_col - 2);
                px.last = (fo + 1 == out_ch);
                pending_outputs.push_back(px);
            end
        end
        cur_ch = 0;
        if (cur_col + 1 >= frame_w) begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= frame_h) ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
    endfunction

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel_out px;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected result tdata=%h", o_m_tdata);
                errors++;
            end else begin
                px = pending_outputs.pop_front();
                if (o_m_tdata[3:0] !== px.value) begin
                    $error("out_value expected %0d actual %0d", px.value, o_m_tdata[3:0]);
                    errors++;
                end
                if (o_m_tdata[7:4] !== px.channel) begin
                    $error("out_channel expected %0d actual %0d", px.channel, o_m_tdata[7:4]);
                    errors++;
                end
                if (o_m_tdata[12:8] !== px.row) begin
                    $error("out_row expected %0d actual %0d", px.row, o_m_tdata[12:8]);
                    errors++;
                end
                if (o_m_tdata[17:13] !== px.col) begin
                    $error("out_col expected %0d actual %0d", px.col, o_m_tdata[17:13]);
                    errors++;
                end
                if (o_m_tlast !== px.last) begin
                    $error("last expected %0d actual %0d", px.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Output back-pressure: random stalls mixed with open stretches.
    initial begin
        int g;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            g = pick_gap();
            if (g > 0) begin
                i_m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Send one item and update the prediction once it is accepted.
    task automatic send_item(logic [1:0] op, logic [31:0] data);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(op, data);
    endtask

    task automatic send_weight(int unsigned idx, logic [3:0] val);
        logic [31:0] d;
        d = $urandom;
        d[11:0] = 12'(idx);
        d[15:12] = val;
        send_item(OP_WEIGHT, d);
    endtask

    task automatic send_bias(int unsigned idx, logic [7:0] val);
        logic [31:0] d;
        d = $urandom;
        d[19:16] = 4'(idx);
        d[27:20] = val;
        send_item(OP_BIAS, d);
    endtask

    task automatic send_act(logic [3:0] val);
        logic [31:0] d;
        d = $urandom;
        d[31:28] = val;
        send_item(OP_ACT, d);
    endtask

    // Wait until every expected result is out and the block has settled.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Register write, only while idle.
    task automatic set_reg(logic [2:0] idx, logic [5:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int unsigned h, int unsigned w, int unsigned ci, int unsigned co,
                             int unsigned ls, int unsigned rs);
        set_reg(REG_HEIGHT, 6'(h));
        set_reg(REG_WIDTH, 6'(w));
        set_reg(REG_IN_CH, 6'(ci));
        set_reg(REG_OUT_CH, 6'(co));
        set_reg(REG_LSHIFT, 6'(ls));
        set_reg(REG_RSHIFT, 6'(rs));
    endtask

    // Fill every weight and bias the current shape reads.
    task automatic load_params();
        for (int i = 0; i < 9 * in_ch * out_ch; i++) send_weight(i, 4'($urandom));
        for (int i = 0; i < out_ch; i++) send_bias(i, 8'($urandom));
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_h * frame_w * in_ch; i++) send_act(4'($urandom));
    endtask

    // Extreme weights, biases and activations on the smallest frame, plus ignored items.
    task automatic test_directed();
        logic [31:0] d;
        configure(3, 3, 1, 2, 0, 0);
        for (int i = 0; i < 9; i++) send_weight(i, 4'sd7);
        for (int i = 9; i < 18; i++) send_weight(i, -4'sd8);
        send_bias(0, 8'sd127);
        send_bias(1, -8'sd128);
        // Unused op and an out-of-range weight index must leave all state alone.
        d = $urandom;
        send_item(OP_NONE, d);
        d = $urandom;
        d[11:0] = 12'hFFF;
        send_item(OP_WEIGHT, d);
        for (int i = 0; i < 9; i++) send_act((i % 2) ? 4'd0 : 4'd15);
    endtask

    // Shift extremes, including a right shift that saturates.
    task automatic test_shifts();
        configure(3, 3, 1, 2, 7, 6);
        load_params();
        send_frame();
        set_reg(REG_LSHIFT, 0);
        set_reg(REG_RSHIFT, 7);
        send_frame();
        set_reg(REG_LSHIFT, 3);
        set_reg(REG_RSHIFT, 0);
        send_frame();
    endtask

    // Several input and output channels on the smallest frame.
    task automatic test_max_channels();
        configure(3, 3, 2, 2, 1, 2);
        load_params();
        send_frame();
    endtask

    // Out-of-range register values, the unused index and the largest frame dimensions.
    task automatic test_frame_limits();
        set_reg(REG_IN_CH, 0);
        set_reg(REG_OUT_CH, 0);
        set_reg(REG_IN_CH, 31);
        set_reg(REG_OUT_CH, 31);
        set_reg(REG_IN_CH, 1);
        set_reg(REG_OUT_CH, 1);
        set_reg(REG_HEIGHT, 0);
        set_reg(REG_WIDTH, 63);
        set_reg(REG_NONE, 6'h2A);
        set_reg(REG_LSHIFT, 0);
        set_reg(REG_RSHIFT, 1);
        load_params();
        send_frame();
        // Tallest frame on the narrowest width: only the first rows are sent.
        set_reg(REG_HEIGHT, 63);
        set_reg(REG_WIDTH, 0);
        for (int i = 0; i < 12; i++) send_act(4'($urandom));
    endtask

    // Random shape; mostly activation items with writes and noise mixed in.
    task automatic test_random();
        logic [31:0] d;
        int r;
        configure($urandom_range(3, 4), $urandom_range(3, 4), 1,
                  $urandom_range(1, 2), $urandom_range(0, 7), $urandom_range(0, 7));
        load_params();
        for (int i = 0; i < 20; i++) begin
            r = $urandom_range(0, 19);
            d = $urandom;
            if (r < 16) begin
                send_item(OP_ACT, d);
            end else if (r == 16) begin
                d[11:0] = 12'($urandom_range(0, WGT_DEPTH - 1));
                send_item(OP_WEIGHT, d);
            end else if (r == 17) begin
                send_item(OP_BIAS, d);
            end else if (r == 18) begin
                d[11:0] = 12'($urandom_range(WGT_DEPTH, 4095));
                send_item(OP_WEIGHT, d);
            end else begin
                send_item(OP_NONE, d);
            end
        end
    endtask

    initial begin
        errors = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        apply_reg(REG_HEIGHT, 32);
        apply_reg(REG_WIDTH, 32);
        apply_reg(REG_IN_CH, 1);
        apply_reg(REG_OUT_CH, 1);
        apply_reg(REG_LSHIFT, 0);
        apply_reg(REG_RSHIFT, 0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_shifts();
        test_max_channels();
        test_frame_limits();
        test_random();
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/c3rq_pkg.sv
rtl/c3rq_datapath.sv
rtl/c3rq_ctrl.sv
rtl/conv3x3_relu_requant_top.sv
verif/testbench.sv
